@@ sv/seed_record_validator_assert.svh @@
// Assertion macros for the seed record validator.
`ifndef SEED_RECORD_VALIDATOR_ASSERT_SVH
`define SEED_RECORD_VALIDATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SRV_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SRV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/srv_pkg.sv @@
// ---------------------------------------------------------------------------
// srv_pkg
// Shared constants, types and CRC helpers for the seed record validator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srv_pkg;

  localparam int SEED_BYTES = 32;
  localparam int SEED_IDX_W = $clog2(SEED_BYTES);
  localparam int POS_W      = 6;
  localparam logic [POS_W-1:0] REC_LEN  = POS_W'(48);
  localparam logic [POS_W-1:0] HDR_LEN  = POS_W'(12);
  localparam logic [POS_W-1:0] CRC_SPAN = POS_W'(44);
  localparam logic [POS_W-1:0] MAGIC_LEN = POS_W'(8);
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BURST = 3'b010,
    ST_FAIL  = 3'b100
  } emit_state_t;

  typedef struct packed {
    logic                  en;
    logic [SEED_IDX_W-1:0] addr;
    logic [7:0]            data;
  } seed_wr_t;

  typedef struct packed {
    logic        fire;
    logic        pass;
    logic        all_zero;
    logic [31:0] generation;
  } verdict_t;

  typedef struct packed {
    logic [7:0]            seed_byte;
    logic [SEED_IDX_W-1:0] seed_index;
    logic [31:0]           generation;
    logic                  record_valid;
    logic                  record_all_zero;
    logic                  last_result;
  } result_t;

  // Reflected CRC-32, one byte, eight unrolled shift steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  // Magic "MPXR", version 1, header size 12.
  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h4D;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h58;
      3'd3:    v = 8'h52;
      3'd4:    v = 8'h00;
      3'd5:    v = 8'h01;
      3'd6:    v = 8'h00;
      3'd7:    v = 8'h0C;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ sv/seed_record_validator.sv @@
// ---------------------------------------------------------------------------
// seed_record_validator
// Checks a CRC-protected seed record streamed one byte per request and emits
// its seed bytes with the generation, or a single failure result.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid / byte_stall) carries data_byte and last_byte.
//   Output channel (result_valid / result_stall) carries one result per
//   request: seed_byte, seed_index, generation and the status flags.
//   Record bytes are taken one per cycle while byte_stall is low. Once the
//   byte marked last is taken, byte_stall rises while the verdict is emitted:
//   a single failure result for a failed or short record, or one seed store read
//   per seed byte for a good one, held longer if the receiver stalls.
//   The first result passes the emit state, seed store read and queue registers.
//   The output side has a two-entry queue with credit-based read issue, so a
//   stalled receiver never loses a result; input bytes of the next record are
//   accepted while earlier results still sit in the queue.
//   rst (synchronous) clears the parser, the emit sequencer and the queue.
//   The seed store has no reset: a good record always rewrites every entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module seed_record_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  seed_byte,
  output logic [4:0]  seed_index,
  output logic [31:0] generation,
  output logic        record_valid,
  output logic        record_all_zero,
  output logic        last_result
);
  import srv_pkg::*;

  `include "seed_record_validator_assert.svh"

  logic        accept;
  seed_wr_t    seed_wr;
  verdict_t    verdict;

  emit_state_t           state;
  logic [SEED_IDX_W-1:0] rd_idx;
  logic [31:0]           emit_gen;
  logic                  fail_zero;

  // read stage (the cycle after issue)
  logic                  rd_valid;
  logic                  rd_fail;
  logic                  rd_zero;
  logic [SEED_IDX_W-1:0] rd_index;
  logic [31:0]           rd_gen;
  logic [7:0]            ram_dout;

  // output queue
  result_t q0, q1, push_item;
  logic    v0, v1, pop;
  logic [1:0] occ_after;
  logic    issue;

  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = (state != ST_IDLE);

  srv_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .seed_wr   (seed_wr),
    .verdict   (verdict)
  );

  srv_ram #(
    .WIDTH (8),
    .DEPTH (SEED_BYTES)
  ) u_seed_ram (
    .clk     (clk),
    .wr_en   (seed_wr.en),
    .wr_addr (seed_wr.addr),
    .wr_data (seed_wr.data),
    .rd_en   (issue && (state == ST_BURST)),
    .rd_addr (rd_idx),
    .rd_data (ram_dout)
  );

  assign pop       = v0 && !result_stall;
  assign occ_after = 2'({1'b0, v0} + {1'b0, v1} - {1'b0, pop});
  // issue only if the queue can absorb this and the in-flight read
  assign issue     = (state != ST_IDLE) && ((occ_after + {1'b0, rd_valid}) < 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_idx   <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      case (state)
        ST_IDLE: begin
          if (verdict.fire) begin
            state <= verdict.pass ? ST_BURST : ST_FAIL;
            rd_idx <= '0;
          end
        end
        ST_BURST: begin
          if (issue) begin
            rd_idx <= rd_idx + SEED_IDX_W'(1);
            if (rd_idx == SEED_IDX_W'(SEED_BYTES - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_FAIL: begin
          if (issue) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.fire) begin
      emit_gen  <= verdict.generation;
      fail_zero <= verdict.all_zero;
    end
    if (issue) begin
      rd_fail  <= (state == ST_FAIL);
      rd_zero  <= fail_zero;
      rd_index <= rd_idx;
      rd_gen   <= emit_gen;
    end
  end

  always_comb begin
    if (rd_fail) begin
      push_item = '{seed_byte: 8'h00, seed_index: '0, generation: 32'h0,
                    record_valid: 1'b0, record_all_zero: rd_zero, last_result: 1'b1};
    end else begin
      push_item = '{seed_byte: ram_dout, seed_index: rd_index, generation: rd_gen,
                    record_valid: 1'b1, record_all_zero: 1'b0,
                    last_result: (rd_index == SEED_IDX_W'(SEED_BYTES - 1))};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      case ({pop, rd_valid})
        2'b01: begin
          if (!v0) begin
            q0 <= push_item;
            v0 <= 1'b1;
          end else begin
            q1 <= push_item;
            v1 <= 1'b1;
          end
        end
        2'b10: begin
          if (v1) begin
            q0 <= q1;
            v1 <= 1'b0;
          end else begin
            v0 <= 1'b0;
          end
        end
        2'b11: begin
          if (v1) begin
            q0 <= q1;
            q1 <= push_item;
          end else begin
            q0 <= push_item;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result_valid    = v0;
  assign seed_byte       = q0.seed_byte;
  assign seed_index      = q0.seed_index;
  assign generation      = q0.generation;
  assign record_valid    = q0.record_valid;
  assign record_all_zero = q0.record_all_zero;
  assign last_result     = q0.last_result;

  `SRV_ASSERT_IMP(a_queue_no_overflow, rd_valid && v1, pop, "result queue overflow")
  `SRV_ASSERT_NEXT(a_last_starts_emit, accept && last_byte, state != ST_IDLE, "no emit after last byte")
  `SRV_ASSERT_IMP(a_good_last_index, result_valid && record_valid && last_result, seed_index == 5'd31, "good record ends off index 31")
  `SRV_ASSERT_IMP(a_fail_zeroed, result_valid && !record_valid, seed_byte == 8'h00 && generation == 32'h0 && last_result, "failure result not cleared")

endmodule

@@ sv/srv_ram.sv @@
// ---------------------------------------------------------------------------
// srv_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/srv_parse.sv @@
// ---------------------------------------------------------------------------
// srv_parse
// Byte-wise record parser: header check, CRC, generation, trailer and the
// seed store write port. Judges the record on the byte marked last.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srv_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output srv_pkg::seed_wr_t seed_wr,
  output srv_pkg::verdict_t verdict
);
  import srv_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [31:0]      running_crc, running_crc_next;
  logic             header_match, header_match_next;
  logic [31:0]      generation_reg, generation_reg_next;
  logic [31:0]      stored_check, stored_check_next;
  logic             nonzero_seen, nonzero_seen_next;
  logic             in_rec;
  logic [POS_W-1:0] seed_off;

  assign in_rec   = byte_position < REC_LEN;
  assign seed_off = byte_position - HDR_LEN;

  always_comb begin
    byte_position_next  = byte_position;
    running_crc_next    = running_crc;
    header_match_next   = header_match;
    generation_reg_next = generation_reg;
    stored_check_next   = stored_check;
    nonzero_seen_next   = nonzero_seen;
    if (in_rec) begin
      byte_position_next = byte_position + POS_W'(1);
      if (data_byte != 8'h00) begin
        nonzero_seen_next = 1'b1;
      end
      if (byte_position < CRC_SPAN) begin
        running_crc_next = crc_byte(running_crc, data_byte);
      end
      if (byte_position < MAGIC_LEN) begin
        if (data_byte != header_byte(byte_position[2:0])) begin
          header_match_next = 1'b0;
        end
      end else if (byte_position < HDR_LEN) begin
        generation_reg_next = {generation_reg[23:0], data_byte};
      end else if (byte_position >= CRC_SPAN) begin
        stored_check_next = {stored_check[23:0], data_byte};
      end
    end
  end

  always_comb begin
    seed_wr.en   = accept && in_rec && (byte_position >= HDR_LEN) &&
                   (byte_position < CRC_SPAN);
    seed_wr.addr = seed_off[SEED_IDX_W-1:0];
    seed_wr.data = data_byte;
  end

  always_comb begin
    verdict.fire       = accept && last_byte;
    verdict.pass       = (byte_position_next == REC_LEN) && header_match_next &&
                         (~running_crc_next == stored_check_next);
    verdict.all_zero   = !nonzero_seen_next;
    verdict.generation = generation_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_position  <= '0;
      running_crc    <= CRC_INIT;
      header_match   <= 1'b1;
      generation_reg <= '0;
      stored_check   <= '0;
      nonzero_seen   <= 1'b0;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      running_crc    <= running_crc_next;
      header_match   <= header_match_next;
      generation_reg <= generation_reg_next;
      stored_check   <= stored_check_next;
      nonzero_seen   <= nonzero_seen_next;
    end
  end

endmodule

@@ tb/sv/seed_record_validator_tb.sv @@
// ---------------------------------------------------------------------------
// seed_record_validator_tb
// Streams seed record buffers into the validator and checks every result
// against a cycle-free predictor of the parser and its CRC-32 check. The
// buffers are one-byte buffers, a good record with trailing bytes and a
// record with a broken header field. Random idling sits on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module seed_record_validator_tb;

  localparam int REC_BYTES   = 48;
  localparam int CRC_BYTES   = 44;
  localparam int HDR_BYTES   = 12;
  localparam int MAGIC_BYTES = 8;
  localparam int SEED_COUNT  = 32;
  localparam logic [31:0] CRC32_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC32_START = 32'hFFFF_FFFF;
  // "MPXR", version 1, header size 12
  localparam logic [63:0] HEADER_WORD = 64'h4D50_5852_0001_000C;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_PCT      = 7;
  localparam int QUIET_FROM    = 60;
  localparam int QUIET_TO      = 130;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    bit         hold;   // wait for all results before this request
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  seed_byte;
  logic [4:0]  seed_index;
  logic [31:0] generation;
  logic        record_valid;
  logic        record_all_zero;
  logic        last_result;

  byte_req_t          pending_bytes[$];
  srv_pkg::result_t   expected_results[$];
  logic [7:0]         rec_bytes[$];

  // predictor state
  int          rec_pos = 0;
  logic [31:0] rec_crc = CRC32_START;
  logic        rec_hdr_ok = 1'b1;
  logic [31:0] rec_gen = '0;
  logic [7:0]  rec_seed[SEED_COUNT];
  logic [31:0] rec_check = '0;
  logic        rec_nonzero = 1'b0;

  int cycle_count = 0;
  int fail_count = 0;
  int good_records = 0;
  int rejected_records = 0;
  int results_checked = 0;
  logic quiet;

  seed_record_validator uut (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .seed_byte       (seed_byte),
    .seed_index      (seed_index),
    .generation      (generation),
    .record_valid    (record_valid),
    .record_all_zero (record_all_zero),
    .last_result     (last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] d);
    c = c ^ {24'd0, d};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Recompute the check word over the first 44 bytes of rec_bytes.
  task automatic seal_crc();
    logic [31:0] c;
    c = CRC32_START;
    for (int i = 0; i < CRC_BYTES; i++) begin
      c = crc32_step(c, rec_bytes[i]);
    end
    c = ~c;
    rec_bytes[44] = c[31:24];
    rec_bytes[45] = c[23:16];
    rec_bytes[46] = c[15:8];
    rec_bytes[47] = c[7:0];
  endtask

  task automatic build_good(input logic [31:0] gen);
    rec_bytes.delete();
    for (int i = 0; i < MAGIC_BYTES; i++) begin
      rec_bytes.push_back(HEADER_WORD[63 - 8*i -: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      rec_bytes.push_back(gen[31 - 8*i -: 8]);
    end
    repeat (SEED_COUNT) rec_bytes.push_back(8'($urandom));
    repeat (4) rec_bytes.push_back(8'h00);
    seal_crc();
  endtask

  task automatic send_rec(input bit hold);
    byte_req_t r;
    for (int i = 0; i < rec_bytes.size(); i++) begin
      r.data = rec_bytes[i];
      r.fin  = (i == rec_bytes.size() - 1);
      r.hold = hold && (i == 0);
      pending_bytes.push_back(r);
    end
  endtask

  task automatic clear_record();
    rec_pos     = 0;
    rec_crc     = CRC32_START;
    rec_hdr_ok  = 1'b1;
    rec_gen     = '0;
    rec_check   = '0;
    rec_nonzero = 1'b0;
  endtask

  // Advance the parser by one byte; on the final byte queue the verdict.
  task automatic absorb_byte(input logic [7:0] d, input logic fin);
    srv_pkg::result_t r;
    if (rec_pos < REC_BYTES) begin
      if (d != 8'h00) rec_nonzero = 1'b1;
      if (rec_pos < CRC_BYTES) rec_crc = crc32_step(rec_crc, d);
      if (rec_pos < MAGIC_BYTES) begin
        if (d != HEADER_WORD[63 - 8*rec_pos -: 8]) rec_hdr_ok = 1'b0;
      end else if (rec_pos < HDR_BYTES) begin
        rec_gen = {rec_gen[23:0], d};
      end else if (rec_pos < CRC_BYTES) begin
        rec_seed[rec_pos - HDR_BYTES] = d;
      end else begin
        rec_check = {rec_check[23:0], d};
      end
      rec_pos++;
    end
    if (fin) begin
      if (rec_pos == REC_BYTES && rec_hdr_ok && (~rec_crc == rec_check)) begin
        for (int i = 0; i < SEED_COUNT; i++) begin
          r.seed_byte       = rec_seed[i];
          r.seed_index      = 5'(i);
          r.generation      = rec_gen;
          r.record_valid    = 1'b1;
          r.record_all_zero = 1'b0;
          r.last_result     = (i == SEED_COUNT - 1);
          expected_results.push_back(r);
        end
        good_records++;
      end else begin
        r.seed_byte       = 8'h00;
        r.seed_index      = 5'd0;
        r.generation      = 32'd0;
        r.record_valid    = 1'b0;
        r.record_all_zero = !rec_nonzero;
        r.last_result     = 1'b1;
        expected_results.push_back(r);
        rejected_records++;
      end
      clear_record();
    end
  endtask

  task automatic note_failure(input string what, input srv_pkg::result_t exp,
                              input srv_pkg::result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s at cycle %0d", what, cycle_count);
      $display("  exp byte=%02h idx=%0d gen=%08h valid=%0b zero=%0b last=%0b",
               exp.seed_byte, exp.seed_index, exp.generation, exp.record_valid,
               exp.record_all_zero, exp.last_result);
      $display("  got byte=%02h idx=%0d gen=%08h valid=%0b zero=%0b last=%0b",
               got.seed_byte, got.seed_index, got.generation, got.record_valid,
               got.record_all_zero, got.last_result);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        absorb_byte(data_byte, last_byte);
      end
      if (!byte_valid || !byte_stall) begin
        if (pending_bytes.size() == 0 ||
            (pending_bytes[0].hold && expected_results.size() != 0) ||
            (!quiet && $urandom_range(0, 99) < IDLE_PCT)) begin
          byte_valid <= 1'b0;
        end else begin
          byte_valid <= 1'b1;
          data_byte  <= pending_bytes[0].data;
          last_byte  <= pending_bytes[0].fin;
          pending_bytes.pop_front();
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    srv_pkg::result_t got;
    srv_pkg::result_t exp;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got.seed_byte       = seed_byte;
        got.seed_index      = seed_index;
        got.generation      = generation;
        got.record_valid    = record_valid;
        got.record_all_zero = record_all_zero;
        got.last_result     = last_result;
        if (expected_results.size() == 0) begin
          exp = '0;
          note_failure("unexpected result", exp, got);
        end else begin
          exp = expected_results.pop_front();
          results_checked++;
          if (got.seed_byte !== exp.seed_byte || got.seed_index !== exp.seed_index ||
              got.generation !== exp.generation ||
              got.record_valid !== exp.record_valid ||
              got.record_all_zero !== exp.record_all_zero ||
              got.last_result !== exp.last_result) begin
            note_failure("result mismatch", exp, got);
          end
        end
      end
      result_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("seed_record_validator: mismatch");
      $finish;
    end
  end

  initial begin
    // one-byte buffers, zero and nonzero
    rec_bytes.delete();
    rec_bytes.push_back(8'h00);
    send_rec(1'b0);
    rec_bytes.delete();
    rec_bytes.push_back(8'hFF);
    send_rec(1'b0);
    // good record, all-ones seed and generation, trailing bytes not examined
    build_good(32'hFFFF_FFFF);
    for (int i = HDR_BYTES; i < CRC_BYTES; i++) rec_bytes[i] = 8'hFF;
    seal_crc();
    repeat (2) rec_bytes.push_back(8'hA5);
    send_rec(1'b1);
    // broken version field under a matching check word
    build_good($urandom);
    rec_bytes[5] ^= 8'h01;
    seal_crc();
    send_rec(1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || byte_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      fail_count += expected_results.size();
    end
    $display("records: %0d good, %0d rejected; %0d results checked, %0d failures",
             good_records, rejected_records, results_checked, fail_count);
    if (fail_count == 0) begin
      $display("seed_record_validator: match");
    end else begin
      $display("seed_record_validator: mismatch");
    end
    $finish;
  end

endmodule
